// File: rtl/core/gmo_pkg.sv
// Shared types, constants and tables of the gradient magnitude/orientation block.
`timescale 1ns / 1ps
`default_nettype none
package gmo_pkg;

  localparam int PIX_W    = 8;
  localparam int CH_N     = 3;
  localparam int GRAD_W   = 11;
  localparam int SQ_W     = 20;
  localparam int GXSQ_W   = 18;
  localparam int ZW       = 20;
  localparam int CORDIC_N = 17;

  localparam logic [15:0] PI_CODE     = 16'd25736;
  localparam logic [14:0] PI_CODE_M1  = 15'd25735;
  localparam logic [17:0] HALF_PI_Q16 = 18'd102944;

  localparam logic [16:0] ATAN_Q16 [CORDIC_N] = '{
    17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024,
    17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2,
    17'd1
  };

  typedef enum logic [1:0] {
    REG_ROWS, REG_COLUMNS, REG_CH_COUNT, REG_FULL_CIRCLE
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_LN, ST_MAGS, ST_MAGW, ST_DIV, ST_QS, ST_QW,
    ST_KSQ, ST_YS, ST_YW, ST_CS, ST_CW, ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [SQ_W-1:0]          s;
    logic [GXSQ_W-1:0]        gxsq;
  } lane_res_t;

endpackage
`default_nettype wire

// File: rtl/core/gradient_magnitude_orientation.sv
// Top level: column stores, lane array, shared square-root/divide/CORDIC sequencer.
// Path: a pixel that yields a result reaches the output register after three square roots, a
//   divider of 2*AB+18 steps (AB = bits of ACOS_STEPS) and the CORDIC; a zero gradient skips
//   the divider and one root. First-column pixels only read and write the stores; ignored
//   words are dropped.
// Throughput: one word at a time; the next word is taken while a result waits at the output.
// Reset: 512 rows, 1024 columns, one channel, half circle; frame restarts; stores not cleared.
`timescale 1ns / 1ps
`default_nettype none
module gradient_magnitude_orientation #(
  parameter int MAX_ROWS    = 512,
  parameter int MAX_COLUMNS = 1024,
  parameter int ACOS_STEPS  = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // sample_ch0, sample_ch1, sample_ch2
  input  wire logic        s_axis_tuser,   // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // magnitude, orientation
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int RB   = $clog2(MAX_ROWS);
  localparam int RCW  = $clog2(MAX_ROWS + 1);
  localparam int CB   = $clog2(MAX_COLUMNS);
  localparam int CCW  = $clog2(MAX_COLUMNS + 1);
  localparam int AB   = $clog2(ACOS_STEPS + 1);
  localparam int N2W  = 2 * AB;
  localparam int RW   = 2 * AB + 32;
  localparam int HW   = RW / 2;
  localparam int DW   = gmo_pkg::GXSQ_W + N2W;
  localparam int DCW  = $clog2(DW + 1);
  localparam int SW   = gmo_pkg::SQ_W;
  localparam logic [N2W-1:0] N2 = N2W'(ACOS_STEPS * ACOS_STEPS);

  gmo_pkg::state_e state_q, state_d;

  logic [9:0]   rows_q;
  logic [10:0]  cols_q;
  logic [1:0]   chc_q;
  logic         full_q;
  logic [RB-1:0] row_q;
  logic [CB-1:0] col_q;
  logic         drain_q;
  logic         out_valid_q;

  logic [RCW-1:0] nrows, y1;
  logic [CCW-1:0] ncols, c1;
  logic [1:0]     nch;
  logic           cfg_we, accept, ignore, last_row, top_row, emit, load_out;

  logic [23:0] newer_mem [MAX_ROWS];
  logic [23:0] older_mem [MAX_ROWS];
  logic [23:0] newer_rd_q, older_rd_q;
  logic        rd_en, wr_en;
  logic [RB-1:0] rd_addr;

  logic [23:0] pix_q, center_q, oldl_q, held_q, above, below, right, left;
  logic        hf2, vf2;
  gmo_pkg::lane_res_t lanes [gmo_pkg::CH_N];
  gmo_pkg::lane_res_t merged, best_q;
  logic        done_q;

  logic [DW-1:0]  a_q;
  logic [SW-1:0]  rem_q;
  logic [DCW-1:0] cnt_q;
  logic [SW:0]    dt;
  logic           dge;

  logic [15:0]    mag_q;
  logic [16:0]    mag_r;
  logic [AB-1:0]  q_q;
  logic           kneg;
  logic [N2W-1:0] ksq_q;
  logic [HW-1:0]  y0_q;
  logic [15:0]    ang_q;
  logic [15:0]    out_mag_q, out_ang_q;
  logic           out_last_q;

  logic           sq_start, sq_busy, sq_done;
  logic [RW-1:0]  sq_rad;
  logic [HW-1:0]  sq_root;
  logic [HW:0]    sq_rem;
  logic           cd_start, cd_done;
  logic [14:0]    cd_code;
  logic signed [AB:0] k_s;

  // configuration -----------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    unique case (gmo_pkg::reg_idx_e'(paddr[3:2]))
      gmo_pkg::REG_ROWS:        prdata = {22'b0, rows_q};
      gmo_pkg::REG_COLUMNS:     prdata = {21'b0, cols_q};
      gmo_pkg::REG_CH_COUNT:    prdata = {30'b0, chc_q};
      gmo_pkg::REG_FULL_CIRCLE: prdata = {31'b0, full_q};
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    if (rows_q < 10'd2) nrows = RCW'(2);
    else if (32'(rows_q) > 32'(MAX_ROWS)) nrows = RCW'(MAX_ROWS);
    else nrows = RCW'(rows_q);
    if (cols_q < 11'd2) ncols = CCW'(2);
    else if (32'(cols_q) > 32'(MAX_COLUMNS)) ncols = CCW'(MAX_COLUMNS);
    else ncols = CCW'(cols_q);
    nch = (chc_q == 2'd0) ? 2'd1 : chc_q;
  end

  // position decode -----------------------------------------------------------
  assign s_axis_tready = (state_q == gmo_pkg::ST_IDLE);
  assign accept   = s_axis_tvalid & s_axis_tready;
  assign ignore   = (s_axis_tuser != drain_q);
  assign y1       = RCW'(row_q) + RCW'(1);
  assign c1       = CCW'(col_q) + CCW'(1);
  assign last_row = (y1 >= nrows);
  assign top_row  = (row_q == '0);
  assign emit     = drain_q || (col_q != '0);

  // column stores -------------------------------------------------------------
  assign rd_en   = (accept && !ignore) || (state_q == gmo_pkg::ST_RD);
  assign rd_addr = (state_q == gmo_pkg::ST_RD) ? y1[RB-1:0] : row_q;
  assign wr_en   = (state_q == gmo_pkg::ST_LN) && !drain_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) newer_rd_q <= newer_mem[rd_addr];
    if (wr_en) newer_mem[row_q] <= pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) older_rd_q <= older_mem[rd_addr];
    if (wr_en) older_mem[row_q] <= center_q;
  end

  // neighbor selection and lanes ----------------------------------------------
  always_comb begin
    above = top_row  ? center_q : held_q;
    below = last_row ? center_q : newer_rd_q;
    vf2   = top_row | last_row;
    if (drain_q) begin
      right = center_q; left = oldl_q; hf2 = 1'b1;
    end else if (col_q == CB'(1)) begin
      right = pix_q; left = center_q; hf2 = 1'b1;
    end else begin
      right = pix_q; left = oldl_q; hf2 = 1'b0;
    end
  end

  for (genvar g = 0; g < gmo_pkg::CH_N; g++) begin : g_lane
    gmo_lane u_lane (
      .right_i (right[8*g +: 8]),
      .left_i  (left[8*g +: 8]),
      .below_i (below[8*g +: 8]),
      .above_i (above[8*g +: 8]),
      .hf2_i   (hf2),
      .vf2_i   (vf2),
      .res_o   (lanes[g])
    );
  end

  gmo_merge u_merge (
    .lanes_i    (lanes),
    .ch_count_i (nch),
    .best_o     (merged)
  );

  // shared arithmetic ---------------------------------------------------------
  always_comb begin
    unique case (state_q)
      gmo_pkg::ST_MAGS: sq_rad = RW'({best_q.s, 12'b0});
      gmo_pkg::ST_QS:   sq_rad = RW'(a_q);
      default:          sq_rad = {N2 - ksq_q, 32'b0};
    endcase
  end
  assign sq_start = (state_q == gmo_pkg::ST_MAGS) || (state_q == gmo_pkg::ST_QS) ||
                    (state_q == gmo_pkg::ST_YS);

  gmo_isqrt #(.W(RW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .busy_o  (sq_busy),
    .done_o  (sq_done),
    .root_o  (sq_root),
    .rem_o   (sq_rem)
  );

  assign kneg     = best_q.gx[gmo_pkg::GRAD_W-1] != best_q.gy[gmo_pkg::GRAD_W-1];
  assign k_s      = kneg ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
  assign cd_start = (state_q == gmo_pkg::ST_CS);

  gmo_cordic #(.AB(AB)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cd_start),
    .k_i     (k_s),
    .y0_i    (y0_q),
    .done_o  (cd_done),
    .code_o  (cd_code)
  );

  assign dt    = {rem_q, a_q[DW-1]};
  assign dge   = dt >= {1'b0, best_q.s};
  assign mag_r = {1'b0, sq_root[15:0]} + ((sq_rem > {1'b0, sq_root}) ? 17'd1 : 17'd0);
  assign load_out = (state_q == gmo_pkg::ST_OUT) && (!out_valid_q || m_axis_tready);

  // sequencer -----------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gmo_pkg::ST_IDLE: if (accept && !ignore) state_d = gmo_pkg::ST_RD;
      gmo_pkg::ST_RD:   state_d = gmo_pkg::ST_LN;
      gmo_pkg::ST_LN:   state_d = emit ? gmo_pkg::ST_MAGS : gmo_pkg::ST_IDLE;
      gmo_pkg::ST_MAGS: state_d = gmo_pkg::ST_MAGW;
      gmo_pkg::ST_MAGW: begin
        if (sq_done) state_d = (best_q.s == '0) ? gmo_pkg::ST_KSQ : gmo_pkg::ST_DIV;
      end
      gmo_pkg::ST_DIV:  if (cnt_q == DCW'(1)) state_d = gmo_pkg::ST_QS;
      gmo_pkg::ST_QS:   state_d = gmo_pkg::ST_QW;
      gmo_pkg::ST_QW:   if (sq_done) state_d = gmo_pkg::ST_KSQ;
      gmo_pkg::ST_KSQ:  state_d = gmo_pkg::ST_YS;
      gmo_pkg::ST_YS:   state_d = gmo_pkg::ST_YW;
      gmo_pkg::ST_YW:   if (sq_done) state_d = gmo_pkg::ST_CS;
      gmo_pkg::ST_CS:   state_d = gmo_pkg::ST_CW;
      gmo_pkg::ST_CW:   if (cd_done) state_d = gmo_pkg::ST_OUT;
      gmo_pkg::ST_OUT:  if (load_out) state_d = gmo_pkg::ST_IDLE;
      default:          state_d = gmo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gmo_pkg::ST_IDLE;
      rows_q      <= 10'd512;
      cols_q      <= 11'd1024;
      chc_q       <= 2'd1;
      full_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (cfg_we) begin
        unique case (gmo_pkg::reg_idx_e'(paddr[3:2]))
          gmo_pkg::REG_ROWS:        rows_q <= pwdata[9:0];
          gmo_pkg::REG_COLUMNS:     cols_q <= pwdata[10:0];
          gmo_pkg::REG_CH_COUNT:    chc_q  <= pwdata[1:0];
          gmo_pkg::REG_FULL_CIRCLE: full_q <= pwdata[0];
          default: ;
        endcase
        row_q   <= '0;
        col_q   <= '0;
        drain_q <= 1'b0;
      end else if (state_q == gmo_pkg::ST_LN) begin
        // advance to the next pixel, wrapping rows into columns and the frame
        if (last_row) begin
          row_q <= '0;
          if (drain_q) begin
            drain_q <= 1'b0;
            col_q   <= '0;
          end else if (c1 >= ncols) begin
            drain_q <= 1'b1;
            col_q   <= '0;
          end else begin
            col_q <= c1[CB-1:0];
          end
        end else begin
          row_q <= y1[RB-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg_we) held_q <= '0;
    else if (state_q == gmo_pkg::ST_LN) held_q <= center_q;
    if (accept) pix_q <= s_axis_tdata;
    unique case (state_q)
      gmo_pkg::ST_RD: begin
        center_q <= newer_rd_q;
        oldl_q   <= older_rd_q;
      end
      gmo_pkg::ST_LN: begin
        best_q <= merged;
        done_q <= drain_q & last_row;
      end
      gmo_pkg::ST_MAGS: begin
        a_q   <= DW'(best_q.gxsq) * DW'(N2);
        rem_q <= '0;
        cnt_q <= DCW'(DW);
      end
      gmo_pkg::ST_MAGW: begin
        if (sq_done) begin
          mag_q <= mag_r[16] ? 16'hFFFF : mag_r[15:0];
          q_q   <= '0;
        end
      end
      gmo_pkg::ST_DIV: begin
        rem_q <= dge ? SW'(dt - {1'b0, best_q.s}) : dt[SW-1:0];
        a_q   <= {a_q[DW-2:0], dge};
        cnt_q <= cnt_q - DCW'(1);
      end
      gmo_pkg::ST_QW: begin
        if (sq_done) begin
          q_q <= (sq_root > HW'(ACOS_STEPS)) ? AB'(ACOS_STEPS) : sq_root[AB-1:0];
        end
      end
      gmo_pkg::ST_KSQ: ksq_q <= N2W'(q_q) * N2W'(q_q);
      gmo_pkg::ST_YW:  if (sq_done) y0_q <= sq_root;
      gmo_pkg::ST_CW: begin
        if (cd_done) begin
          ang_q <= {1'b0, cd_code} +
                   ((full_q && best_q.gy[gmo_pkg::GRAD_W-1]) ? gmo_pkg::PI_CODE : 16'd0);
        end
      end
      gmo_pkg::ST_OUT: begin
        if (load_out) begin
          out_mag_q  <= mag_q;
          out_ang_q  <= ang_q;
          out_last_q <= done_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_ang_q, out_mag_q};
  assign m_axis_tlast  = out_last_q;

  // checks ------------------------------------------------------------------
  a_drain_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> col_q == '0) else $error("column position moved while draining");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    RCW'(row_q) < nrows || $past(cfg_we)) else $error("row position beyond image height");

  a_sqrt_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> !sq_busy) else $error("square root restarted while busy");

  a_q_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gmo_pkg::ST_KSQ |-> 32'(q_q) <= 32'(ACOS_STEPS))
    else $error("cosine step out of range");
endmodule
`default_nettype wire

// File: rtl/core/gmo_lane.sv
// One channel lane: central differences, doubled at the image edges, and squared magnitude.
`timescale 1ns / 1ps
`default_nettype none
module gmo_lane (
  input  wire logic [gmo_pkg::PIX_W-1:0] right_i,
  input  wire logic [gmo_pkg::PIX_W-1:0] left_i,
  input  wire logic [gmo_pkg::PIX_W-1:0] below_i,
  input  wire logic [gmo_pkg::PIX_W-1:0] above_i,
  input  wire logic                      hf2_i,
  input  wire logic                      vf2_i,
  output gmo_pkg::lane_res_t             res_o
);
  logic signed [gmo_pkg::PIX_W:0]      dx, dy;
  logic signed [gmo_pkg::GRAD_W-1:0]   gx, gy;
  logic signed [2*gmo_pkg::GRAD_W-1:0] gx2, gy2;

  always_comb begin
    dx  = $signed({1'b0, right_i}) - $signed({1'b0, left_i});
    dy  = $signed({1'b0, below_i}) - $signed({1'b0, above_i});
    gx  = hf2_i ? {dx[gmo_pkg::PIX_W], dx, 1'b0} : {{2{dx[gmo_pkg::PIX_W]}}, dx};
    gy  = vf2_i ? {dy[gmo_pkg::PIX_W], dy, 1'b0} : {{2{dy[gmo_pkg::PIX_W]}}, dy};
    gx2 = gx * gx;
    gy2 = gy * gy;
    res_o.gx   = gx;
    res_o.gy   = gy;
    res_o.gxsq = gx2[gmo_pkg::GXSQ_W-1:0];
    res_o.s    = gx2[gmo_pkg::SQ_W-1:0] + gy2[gmo_pkg::SQ_W-1:0];
  end
endmodule
`default_nettype wire

// File: rtl/core/gmo_merge.sv
// Merge of the channel lanes: keep the largest squared magnitude, lowest channel on a tie.
`timescale 1ns / 1ps
`default_nettype none
module gmo_merge (
  input  wire gmo_pkg::lane_res_t lanes_i [gmo_pkg::CH_N],
  input  wire logic [1:0]         ch_count_i,
  output gmo_pkg::lane_res_t      best_o
);
  always_comb begin
    best_o = lanes_i[0];
    if (ch_count_i >= 2'd2 && lanes_i[1].s > best_o.s) best_o = lanes_i[1];
    if (ch_count_i == 2'd3 && lanes_i[2].s > best_o.s) best_o = lanes_i[2];
  end
endmodule
`default_nettype wire

// File: rtl/core/gmo_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle, with remainder.
`timescale 1ns / 1ps
`default_nettype none
module gmo_isqrt #(
  parameter int W = 54
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [W-1:0]   rad_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [W/2-1:0]      root_o,
  output logic [W/2:0]        rem_o
);
  logic [W-1:0] v_q, r_q, bit_q, sum;
  logic         run_q, done_q;

  assign sum = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && bit_q[0]) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= rad_i;
      r_q   <= '0;
      bit_q <= {2'b01, {(W-2){1'b0}}};
    end else if (run_q) begin
      if (v_q >= sum) begin
        v_q <= v_q - sum;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = run_q;
  assign done_o = done_q;
  assign root_o = r_q[W/2-1:0];
  assign rem_o  = v_q[W/2:0];
endmodule
`default_nettype wire

// File: rtl/core/gmo_cordic.sv
// Iterative CORDIC vectoring: arccos code from the cosine step k and the sine leg.
`timescale 1ns / 1ps
`default_nettype none
module gmo_cordic #(
  parameter int AB = 11
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic signed [AB:0] k_i,
  input  wire logic [AB+15:0]    y0_i,
  output logic                   done_o,
  output logic [14:0]            code_o
);
  localparam int CW = AB + 19;

  logic signed [CW-1:0]         x_q, y_q, kx, sx, sy;
  logic signed [gmo_pkg::ZW-1:0] z_q, at;
  logic [4:0]                   i_q;
  logic                         run_q, done_q;
  logic [gmo_pkg::ZW-1:0]       zc, zr;

  function automatic logic signed [CW-1:0] shr_tz(logic signed [CW-1:0] v, logic [4:0] s);
    logic signed [CW-1:0] m;
    begin
      m = -v;
      shr_tz = v[CW-1] ? -(m >>> s) : (v >>> s);
    end
  endfunction

  assign kx = {{2{k_i[AB]}}, k_i, 16'b0};
  assign sx = shr_tz(x_q, i_q);
  assign sy = shr_tz(y_q, i_q);
  assign at = $signed({3'b000, gmo_pkg::ATAN_Q16[i_q]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && i_q == 5'(gmo_pkg::CORDIC_N - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      i_q <= '0;
      if (k_i[AB]) begin
        // rotate a left-half vector by -pi/2 first
        x_q <= $signed({3'b000, y0_i});
        y_q <= -kx;
        z_q <= $signed({2'b00, gmo_pkg::HALF_PI_Q16});
      end else begin
        x_q <= kx;
        y_q <= $signed({3'b000, y0_i});
        z_q <= '0;
      end
    end else if (run_q) begin
      i_q <= i_q + 5'd1;
      if (y_q > 0) begin
        x_q <= x_q + sy;
        y_q <= y_q - sx;
        z_q <= z_q + at;
      end else if (y_q < 0) begin
        x_q <= x_q - sy;
        y_q <= y_q + sx;
        z_q <= z_q - at;
      end
    end
  end

  always_comb begin
    zc = z_q[gmo_pkg::ZW-1] ? '0 : z_q;
    zr = (zc + gmo_pkg::ZW'(4)) >> 3;
    code_o = (zr > gmo_pkg::ZW'(gmo_pkg::PI_CODE_M1)) ? gmo_pkg::PI_CODE_M1 : zr[14:0];
  end

  assign done_o = done_q;
endmodule
`default_nettype wire

// File: bench/tb_gradient_magnitude_orientation.sv
// Self-checking testbench for the gradient magnitude/orientation block.
`timescale 1ns / 1ps
module tb_gradient_magnitude_orientation;

  localparam int MAX_ROWS   = 512;
  localparam int MAX_COLS   = 1024;
  localparam int ACOS_STEPS = 1024;
  localparam int SETTLE     = 250;

  typedef struct packed {
    logic        drain;
    logic [23:0] pix;
  } pixel_word_t;

  typedef struct packed {
    logic [15:0] mag;
    logic [15:0] ang;
    logic        last;
  } grad_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // sample_ch0, sample_ch1, sample_ch2
  logic s_axis_tuser = 1'b0;       // operation
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // magnitude, orientation
  logic m_axis_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gradient_magnitude_orientation u_top (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [23:0] older_col [MAX_ROWS];
  logic [23:0] newer_col [MAX_ROWS];
  int unsigned row_pos, col_pos;
  logic [23:0] above_hold;
  bit flushing;
  logic [9:0]  cfg_rows;
  logic [10:0] cfg_cols;
  logic [1:0]  cfg_ch;
  logic        cfg_full;

  pixel_word_t pixel_q[$];
  grad_t       grad_q[$];
  int n_words, n_results, n_frames, n_errors;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint shr_tz(longint v, int s);
    return (v >= 0) ? (v >>> s) : -((-v) >>> s);
  endfunction

  function automatic logic [15:0] acos_lookup(longint k);
    longint n, x, y, z, t;
    n = ACOS_STEPS;
    x = k * 65536;
    y = longint'(root64(longint'(n * n - k * k) << 32));
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = longint'(gmo_pkg::HALF_PI_Q16);
    end
    for (int i = 0; i < gmo_pkg::CORDIC_N; i++) begin
      if (y > 0) begin
        t = x + shr_tz(y, i);
        y = y - shr_tz(x, i);
        x = t;
        z += longint'(gmo_pkg::ATAN_Q16[i]);
      end else if (y < 0) begin
        t = x - shr_tz(y, i);
        y = y + shr_tz(x, i);
        x = t;
        z -= longint'(gmo_pkg::ATAN_Q16[i]);
      end
    end
    if (z < 0) z = 0;
    z = (z + 4) >>> 3;
    if (z > longint'(gmo_pkg::PI_CODE) - 1) z = longint'(gmo_pkg::PI_CODE) - 1;
    return z[15:0];
  endfunction

  function automatic void restart_frame();
    row_pos = 0;
    col_pos = 0;
    above_hold = '0;
    flushing = 0;
  endfunction

  // Advance the predictor by one accepted word; queue a result if one is due.
  function automatic void predict_gradient(pixel_word_t w);
    int unsigned nr, nc, nch, yy, hf, vf;
    logic [23:0] ctr, abv, blw, lft, rgt;
    longint gx, gy, s, bs, bgx, bgy, k;
    longint unsigned xm, r, q;
    grad_t g;
    nr = (cfg_rows < 2) ? 2 : (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
    nc = (cfg_cols < 2) ? 2 : (cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols;
    nch = (cfg_ch == 0) ? 1 : cfg_ch;
    if (w.drain != flushing) return;
    yy = row_pos;
    ctr = newer_col[yy];
    if (flushing || col_pos > 0) begin
      abv = (yy > 0) ? above_hold : ctr;
      blw = (yy + 1 < nr) ? newer_col[yy + 1] : ctr;
      vf = (yy == 0 || yy + 1 >= nr) ? 2 : 1;
      if (flushing) begin
        rgt = ctr; lft = older_col[yy]; hf = 2;
      end else if (col_pos == 1) begin
        rgt = w.pix; lft = ctr; hf = 2;
      end else begin
        rgt = w.pix; lft = older_col[yy]; hf = 1;
      end
      bs = 0; bgx = 0; bgy = 0;
      for (int c = 0; c < nch; c++) begin
        gx = (longint'(rgt[8*c +: 8]) - longint'(lft[8*c +: 8])) * hf;
        gy = (longint'(blw[8*c +: 8]) - longint'(abv[8*c +: 8])) * vf;
        s = gx * gx + gy * gy;
        if (c == 0 || s > bs) begin
          bs = s; bgx = gx; bgy = gy;
        end
      end
      xm = bs * 4096;
      r = root64(xm);
      if (xm - r * r > r) r++;
      if (r > 65535) r = 65535;
      q = 0;
      if (bs > 0) q = root64((bgx * bgx * ACOS_STEPS * ACOS_STEPS) / bs);
      if (q > ACOS_STEPS) q = ACOS_STEPS;
      k = ((bgx < 0) != (bgy < 0)) ? -longint'(q) : longint'(q);
      g.mag = r[15:0];
      g.ang = acos_lookup(k);
      if (cfg_full && bgy < 0) g.ang += gmo_pkg::PI_CODE;
      g.last = flushing && (yy + 1 >= nr);
      grad_q.push_back(g);
    end
    above_hold = ctr;
    if (!flushing) begin
      older_col[yy] = ctr;
      newer_col[yy] = w.pix;
    end
    if (yy + 1 >= nr) begin
      row_pos = 0;
      if (flushing) begin
        flushing = 0;
        col_pos = 0;
      end else if (col_pos + 1 >= nc) begin
        flushing = 1;
        col_pos = 0;
      end else begin
        col_pos++;
      end
    end else begin
      row_pos = yy + 1;
    end
  endfunction

  // Driver: bursts of random length, random gaps between them
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    pixel_word_t w;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_gradient('{drain: s_axis_tuser, pix: s_axis_tdata});
        n_words++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          w = pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= w.drain;
          s_axis_tdata <= w.pix;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 1) ? $urandom_range(20, 200) : $urandom_range(0, 6);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 180);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: receiver stall pattern changes mode at random intervals
  int ready_mode = 0, mode_cnt = 0;
  always @(posedge clk_i) begin
    grad_t g;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (m_axis_tlast) n_frames++;
        if (grad_q.size() == 0) begin
          $error("unexpected result: magnitude %0d orientation %0d",
                 m_axis_tdata[15:0], m_axis_tdata[31:16]);
          n_errors++;
        end else begin
          g = grad_q.pop_front();
          if (m_axis_tdata[15:0] !== g.mag) begin
            $error("magnitude: expected %0d, got %0d", g.mag, m_axis_tdata[15:0]);
            n_errors++;
          end
          if (m_axis_tdata[31:16] !== g.ang) begin
            $error("orientation: expected %0d, got %0d", g.ang, m_axis_tdata[31:16]);
            n_errors++;
          end
          if (m_axis_tlast !== g.last) begin
            $error("frame_done: expected %0d, got %0d", g.last, m_axis_tlast);
            n_errors++;
          end
        end
      end
      if (mode_cnt == 0) begin
        mode_cnt = $urandom_range(50, 600);
        ready_mode = $urandom_range(0, 3);
      end else begin
        mode_cnt--;
      end
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  task automatic wait_drained();
    while (pixel_q.size() > 0 || s_axis_tvalid || grad_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_write(gmo_pkg::reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      gmo_pkg::REG_ROWS:     cfg_rows = val[9:0];
      gmo_pkg::REG_COLUMNS:  cfg_cols = val[10:0];
      gmo_pkg::REG_CH_COUNT: cfg_ch = val[1:0];
      default:               cfg_full = val[0];
    endcase
    restart_frame();
  endtask

  task automatic configure(int r, int c, int ch, int full);
    wait_drained();
    apb_write(gmo_pkg::REG_ROWS, r);
    apb_write(gmo_pkg::REG_COLUMNS, c);
    apb_write(gmo_pkg::REG_CH_COUNT, ch);
    apb_write(gmo_pkg::REG_FULL_CIRCLE, full);
  endtask

  function automatic logic [23:0] make_pixel(int style, logic [23:0] prev);
    logic [23:0] p;
    case (style)
      0: p = 24'($urandom);
      1: for (int c = 0; c < 3; c++) p[8*c +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: p = '0;
      default:
        for (int c = 0; c < 3; c++)
          p[8*c +: 8] = 8'(prev[8*c +: 8] + $urandom_range(0, 12) - 6);
    endcase
    return p;
  endfunction

  // Queue one frame; noise adds drains mid-frame and samples during the flush.
  // A limit below the frame size stops the frame early.
  task automatic queue_frame(int nr, int nc, int style, int noise, int limit);
    logic [23:0] p;
    int cnt;
    p = 24'($urandom);
    cnt = 0;
    for (int c = 0; c < nc; c++) begin
      for (int r = 0; r < nr; r++) begin
        if (cnt++ >= limit) return;
        if (noise > 0 && $urandom_range(0, 99) < noise)
          pixel_q.push_back('{1'b1, 24'($urandom)});
        p = make_pixel(style, p);
        pixel_q.push_back('{1'b0, p});
      end
    end
    for (int r = 0; r < nr; r++) begin
      if (noise > 0 && $urandom_range(0, 99) < noise)
        pixel_q.push_back('{1'b0, 24'($urandom)});
      pixel_q.push_back('{1'b1, 24'($urandom)});
    end
  endtask

  initial begin
    int nr, nc;
    cfg_rows = 10'd512;
    cfg_cols = 11'd1024;
    cfg_ch = 2'd1;
    cfg_full = 1'b0;
    n_words = 0; n_results = 0; n_frames = 0; n_errors = 0;
    for (int i = 0; i < MAX_ROWS; i++) begin
      older_col[i] = '0;
      newer_col[i] = '0;
    end
    restart_frame();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes on three channels, drain before the last column,
    // sample during the flush, then a flat frame for the zero gradient
    configure(3, 3, 3, 1);
    pixel_q.push_back('{1'b1, 24'hFFFFFF});
    queue_frame(3, 3, 1, 0, 1 << 30);
    pixel_q.insert(5, '{1'b1, 24'h000000});
    pixel_q.insert(pixel_q.size() - 1, '{1'b0, 24'hFFFFFF});
    queue_frame(3, 3, 2, 0, 1 << 30);

    // Out-of-range values clamp to two rows, two columns, one channel
    configure(0, 1, 0, 0);
    repeat (2) queue_frame(2, 2, 1, 10, 1 << 30);

    for (int ph = 0; ph < 3; ph++) begin
      nr = $urandom_range(2, 8);
      nc = $urandom_range(2, 6);
      configure(nr, nc, $urandom_range(0, 3), $urandom_range(0, 1));
      repeat ($urandom_range(1, 3))
        queue_frame(nr, nc, $urandom_range(0, 3), $urandom_range(0, 1) ? 0 : 8, 1 << 30);
    end

    // Largest images: height clamped to the full store and wrapped into the
    // second column, a wide one cut short by the next write
    configure(1023, 2, 3, 1);
    queue_frame(512, 2, 0, 0, 514);
    configure(2, 2047, 2, 0);
    queue_frame(2, 2047, 3, 0, 24);
    configure(4, 3, 3, 1);
    queue_frame(4, 3, 0, 5, 1 << 30);

    wait_drained();
    $display("Covered %0d accepted words, %0d results, %0d completed frames,",
             n_words, n_results, n_frames);
    $display("over clamped and extreme sizes, one to three channels, both angle ranges.");
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding", grad_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/gmo_pkg.sv
rtl/core/gmo_lane.sv
rtl/core/gmo_merge.sv
rtl/core/gmo_isqrt.sv
rtl/core/gmo_cordic.sv
rtl/core/gradient_magnitude_orientation.sv
bench/tb_gradient_magnitude_orientation.sv
